@@ src/nimf_pkg.sv @@
// Package for the nim-field multiplier: the 64-bit field width and the
// power-of-two nim multiply functions, one per field level.
// No dependencies.
`default_nettype none
package nimf_pkg;

   localparam int unsigned FIELD_BITS = 64;
   localparam int unsigned EXP_BITS   = 6;

   typedef logic [FIELD_BITS-1:0] word_type;
   typedef logic [EXP_BITS-1:0]   exp_type;

   // Level 1: field of 4 elements, operand below 2^2, exponent below 2.
   function automatic word_type pow_mul_l1(input word_type a, input exp_type j);
      word_type a0;
      word_type a1;
      word_type hi;
      word_type lo;
      a0 = {63'd0, a[0]};
      a1 = {63'd0, a[1]};
      if (j[0]) begin
         hi = a1 ^ a0;
         lo = a1;
      end else begin
         hi = a1;
         lo = a0;
      end
      return {62'd0, hi[0], lo[0]};
   endfunction

   // Level 2: field below 2^4, exponent below 4.
   function automatic word_type pow_mul_l2(input word_type a, input exp_type j);
      word_type p0;
      word_type p1;
      word_type hi;
      word_type lo;
      exp_type  jj;
      jj = {5'd0, j[0]};
      p0 = pow_mul_l1({62'd0, a[1:0]}, jj);
      p1 = pow_mul_l1({62'd0, a[3:2]}, jj);
      if (j[1]) begin
         hi = p1 ^ p0;
         lo = pow_mul_l1(p1, exp_type'(1));
      end else begin
         hi = p1;
         lo = p0;
      end
      return {60'd0, hi[1:0], lo[1:0]};
   endfunction

   // Level 3: field below 2^8, exponent below 8.
   function automatic word_type pow_mul_l3(input word_type a, input exp_type j);
      word_type p0;
      word_type p1;
      word_type hi;
      word_type lo;
      exp_type  jj;
      jj = {4'd0, j[1:0]};
      p0 = pow_mul_l2({60'd0, a[3:0]}, jj);
      p1 = pow_mul_l2({60'd0, a[7:4]}, jj);
      if (j[2]) begin
         hi = p1 ^ p0;
         lo = pow_mul_l2(p1, exp_type'(3));
      end else begin
         hi = p1;
         lo = p0;
      end
      return {56'd0, hi[3:0], lo[3:0]};
   endfunction

   // Level 4: field below 2^16, exponent below 16.
   function automatic word_type pow_mul_l4(input word_type a, input exp_type j);
      word_type p0;
      word_type p1;
      word_type hi;
      word_type lo;
      exp_type  jj;
      jj = {3'd0, j[2:0]};
      p0 = pow_mul_l3({56'd0, a[7:0]}, jj);
      p1 = pow_mul_l3({56'd0, a[15:8]}, jj);
      if (j[3]) begin
         hi = p1 ^ p0;
         lo = pow_mul_l3(p1, exp_type'(7));
      end else begin
         hi = p1;
         lo = p0;
      end
      return {48'd0, hi[7:0], lo[7:0]};
   endfunction

   // Level 5: field below 2^32, exponent below 32.
   function automatic word_type pow_mul_l5(input word_type a, input exp_type j);
      word_type p0;
      word_type p1;
      word_type hi;
      word_type lo;
      exp_type  jj;
      jj = {2'd0, j[3:0]};
      p0 = pow_mul_l4({48'd0, a[15:0]}, jj);
      p1 = pow_mul_l4({48'd0, a[31:16]}, jj);
      if (j[4]) begin
         hi = p1 ^ p0;
         lo = pow_mul_l4(p1, exp_type'(15));
      end else begin
         hi = p1;
         lo = p0;
      end
      return {32'd0, hi[15:0], lo[15:0]};
   endfunction

   // Level 6: full 64-bit field, exponent below 64.
   function automatic word_type pow_mul_l6(input word_type a, input exp_type j);
      word_type p0;
      word_type p1;
      word_type hi;
      word_type lo;
      exp_type  jj;
      jj = {1'b0, j[4:0]};
      p0 = pow_mul_l5({32'd0, a[31:0]}, jj);
      p1 = pow_mul_l5({32'd0, a[63:32]}, jj);
      if (j[5]) begin
         hi = p1 ^ p0;
         lo = pow_mul_l5(p1, exp_type'(31));
      end else begin
         hi = p1;
         lo = p0;
      end
      return {hi[31:0], lo[31:0]};
   endfunction

endpackage
`default_nettype wire

@@ src/nimf_pow_unit.sv @@
// Shared unit: nim product of a 64-bit operand with the power of two 2^j,
// registered. Uses nimf_pkg.
`default_nettype none
module nimf_pow_unit (
   input  wire logic              clock,
   input  wire nimf_pkg::word_type operand,
   input  wire nimf_pkg::exp_type  exponent,
   output nimf_pkg::word_type      term
);
   import nimf_pkg::*;

   word_type term_ff;
   word_type term_in;

   // Recursive split over the Fermat-power levels
   always_comb begin
      term_in = pow_mul_l6(operand, exponent);
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule
`default_nettype wire

@@ src/nim_field_multiplier.sv @@
// Top level of the nim-field multiplier: sequencer and accumulator around
// the shared power multiply unit. Uses nimf_pkg and nimf_pow_unit.
//
//   channel | ports                                     | handshake
//   req     | req_left_operand, req_right_operand       | start, busy
//   rsp     | rsp_nim_product                           | rsp_valid strobe
//
// Each word is sequenced one bit of the right operand per cycle through the
// power multiply unit, then passes the unit's term register and the output
// register before the rsp_valid strobe.
// busy is high from acceptance until the result strobe; start is ignored then.
// Reset (synchronous, active high) returns the sequencer to idle.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none
module nim_field_multiplier #(
   parameter int unsigned OPERAND_BITS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire nimf_pkg::word_type req_left_operand,
   input  wire nimf_pkg::word_type req_right_operand,
   output logic                    rsp_valid,
   output nimf_pkg::word_type      rsp_nim_product
);
   import nimf_pkg::*;

   localparam int unsigned CNT_W = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(OPERAND_BITS - 1);
   localparam word_type OP_MASK = word_type'({FIELD_BITS{1'b1}} >> (FIELD_BITS - OPERAND_BITS));

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] bit_ff;
   word_type         left_ff;
   word_type         right_ff;
   logic             take_ff;
   word_type         acc_ff;
   logic             valid_ff;
   word_type         product_ff;
   word_type         term;

   nimf_pow_unit u_pow (
      .clock    (clock),
      .operand  (left_ff),
      .exponent (exp_type'(bit_ff)),
      .term     (term)
   );

   // Sequencer: one right-operand bit per cycle, accumulate the unit output
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         take_ff  <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               take_ff <= 1'b0;
               if (start) begin
                  left_ff  <= req_left_operand & OP_MASK;
                  right_ff <= req_right_operand & OP_MASK;
                  bit_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               // term from the previous bit arrives this cycle
               if (take_ff) begin
                  acc_ff <= acc_ff ^ term;
               end
               take_ff  <= right_ff[0];
               right_ff <= right_ff >> 1;
               if (bit_ff == LAST_BIT) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  bit_ff <= bit_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               product_ff <= take_ff ? (acc_ff ^ term) : acc_ff;
               valid_ff   <= 1'b1;
               take_ff    <= 1'b0;
               state_ff   <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_nim_product = product_ff;

endmodule
`default_nettype wire

@@ tb/sv/nim_field_multiplier_tb.sv @@
// Testbench for nim_field_multiplier: drives operand pairs through the
// start/busy handshake and checks each product against a nim-product predictor.
// Depends on nimf_pkg and nim_field_multiplier.
`default_nettype none
module nim_field_multiplier_tb;
   import nimf_pkg::*;

   localparam int unsigned OPERAND_BITS = 64;
   localparam int unsigned RANDOM_WORDS = 1650;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      word_type left;
      word_type right;
   } operand_pair_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   word_type req_left_operand  = '0;
   word_type req_right_operand = '0;
   logic     rsp_valid;
   word_type rsp_nim_product;

   operand_pair_type pending_pairs[$];
   word_type         expected_products[$];
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      gap_left    = 0;
   logic             feed_done   = 1'b0;
   logic             accepted    = 1'b0;

   nim_field_multiplier #(.OPERAND_BITS(OPERAND_BITS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_left_operand (req_left_operand),
      .req_right_operand(req_right_operand),
      .rsp_valid        (rsp_valid),
      .rsp_nim_product  (rsp_nim_product)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Recursive Karatsuba-style nim product over a field of the given width
   function automatic word_type nim_product_width(word_type a, word_type b, int unsigned width);
      int unsigned half;
      word_type    low_mask;
      word_type    c;
      word_type    d;
      word_type    e;
      word_type    hi;
      word_type    lo;
      if (width <= 1) return a & b & word_type'(1);
      half     = width / 2;
      low_mask = (word_type'(1) << half) - 1;
      c  = nim_product_width(a & low_mask, b & low_mask, half);
      d  = nim_product_width((a >> half) & low_mask, (b >> half) & low_mask, half);
      e  = nim_product_width((a ^ (a >> half)) & low_mask, (b ^ (b >> half)) & low_mask, half);
      hi = e ^ c;
      lo = c ^ nim_product_width(d, word_type'(1) << (half - 1), half);
      return ((hi & low_mask) << half) | (lo & low_mask);
   endfunction

   function automatic word_type predict_nim_product(word_type left, word_type right);
      word_type op_mask;
      word_type a;
      word_type b;
      op_mask = {64{1'b1}} >> (64 - OPERAND_BITS);
      a = left & op_mask;
      b = right & op_mask;
      if (a == 0 || b == 0) return '0;
      if (a == 1) return b;
      if (b == 1) return a;
      return nim_product_width(a, b, FIELD_BITS);
   endfunction

   function automatic word_type random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Operand mix: full random, shifted random, single powers of two, Fermat powers, small values
   function automatic word_type shaped_operand();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: begin
            return word_type'(1) << $urandom_range(0, 63);
         end
         2: begin
            return word_type'(1) << (1 << $urandom_range(0, 5));
         end
         3: begin
            return word_type'($urandom_range(0, 255));
         end
         4: begin
            return random_word() >> $urandom_range(0, 63);
         end
         default: begin
            return random_word();
         end
      endcase
   endfunction

   function automatic int unsigned idle_length();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   task automatic queue_pair(word_type left, word_type right);
      operand_pair_type p;
      p.left  = left;
      p.right = right;
      pending_pairs.push_back(p);
   endtask

   // Stimulus: directed corner cases, then shaped random pairs
   initial begin
      queue_pair('0, '0);
      queue_pair('0, {64{1'b1}});
      queue_pair({64{1'b1}}, '0);
      queue_pair(64'd1, {64{1'b1}});
      queue_pair({64{1'b1}}, 64'd1);
      queue_pair(64'd1, 64'd1);
      queue_pair({64{1'b1}}, {64{1'b1}});
      queue_pair(64'd2, 64'd2);
      queue_pair(64'd4, 64'd4);
      queue_pair(64'd16, 64'd16);
      queue_pair(64'd256, 64'd256);
      queue_pair(64'd65536, 64'd65536);
      queue_pair(64'h1_0000_0000, 64'h1_0000_0000);
      queue_pair(64'd2, 64'd4);
      queue_pair(64'd256, 64'h1_0000_0000);
      queue_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      queue_pair(64'h8000_0000_0000_0000, 64'd3);
      queue_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      queue_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_pair(64'd3, 64'd3);
      for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
         queue_pair(shaped_operand(), shaped_operand());
      end
      feed_done = 1'b1;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Driver: present a word at the falling edge; once it is taken, drop start or present the next word
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || accepted) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               start    <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
               req_left_operand  <= pending_pairs[0].left;
               req_right_operand <= pending_pairs[0].right;
               pending_pairs.pop_front();
               start    <= 1'b1;
               gap_left <= idle_length();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: acceptance and result checking at the rising edge
   always @(posedge clock) begin
      word_type want;
      cycle_count <= cycle_count + 1;
      accepted    <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            expected_products.push_back(predict_nim_product(req_left_operand,
                                                            req_right_operand));
         end
         if (rsp_valid) begin
            if (expected_products.size() == 0) begin
               $display("%0t: unexpected product %h", $time, rsp_nim_product);
               error_count <= error_count + 1;
            end else begin
               want = expected_products.pop_front();
               if (rsp_nim_product !== want) begin
                  $display("%0t: nim_product expected %h actual %h",
                           $time, want, rsp_nim_product);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

   // End of run: drain, settle, then report
   initial begin
      wait (feed_done && pending_pairs.size() == 0 && !start
            && expected_products.size() == 0);
      repeat (OPERAND_BITS + 8) @(posedge clock);
      if (error_count == 0 && expected_products.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Timeout
   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
`default_nettype wire
